@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the dispatcher rtl
// every macro expects clk and arst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/fcfsd_pkg.sv @@
// shared constants, codes and control structs of the fcfs dispatcher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fcfsd_pkg;

	// sizing
	localparam int MAX_SERVERS = 10;
	localparam int QUEUE_DEPTH = 16;
	localparam int SRV_CNT_W   = 4;
	localparam int SRV_IDX_W   = 4;
	localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int TAG_W       = 16;
	localparam int TIME_W      = 16;
	localparam int FACT_W      = 8;

	// request kinds
	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// result kinds
	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_DROP   = 2'd2
	} result_kind_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ARRIVE,
		ST_VISIT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic arrive;
		logic visit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_tick;
		logic count_zero;
		logic last_visit;
		logic out_free;
	} ctrl_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/fcfsd_ctrl.sv @@
// controller state machine of the fcfs dispatcher
// depends on fcfsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcfsd_ctrl
	import fcfsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire ctrl_stat_t stat,
	output ctrl_cmd_t       cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!stat.in_tick) begin
						state_nxt = ST_ARRIVE;
					end else if (!stat.count_zero) begin
						state_nxt = ST_VISIT;
					end
				end
			end
			ST_ARRIVE: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_VISIT: begin
				if (stat.out_free && stat.last_visit) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_stall    = 1'b1;
		cmd.load_in = 1'b0;
		cmd.arrive  = 1'b0;
		cmd.visit   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_ARRIVE: begin
				cmd.arrive = stat.out_free;
			end
			ST_VISIT: begin
				cmd.visit = stat.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/fcfsd_datapath.sv @@
// datapath of the fcfs dispatcher: job queue, server table, output register
// depends on fcfsd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fcfsd_datapath
	import fcfsd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [SRV_CNT_W-1:0] cfg_data,
	// request fields
	input  wire logic                 func,
	input  wire logic [TAG_W-1:0]     job_tag,
	input  wire logic [FACT_W-1:0]    job_weight,
	input  wire logic [FACT_W-1:0]    job_amount,
	// control
	input  wire ctrl_cmd_t            cmd,
	output ctrl_stat_t                stat,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                result_kind,
	output logic [SRV_IDX_W-1:0]      server_index,
	output logic [TAG_W-1:0]          served_tag,
	output logic [TIME_W-1:0]         time_left,
	output logic                      server_busy,
	output logic                      last_of_run
);

	// configuration and control registers
	logic [SRV_CNT_W-1:0] server_count_q;
	logic [SRV_IDX_W-1:0] idx_q;
	logic [Q_IDX_W-1:0]   head_q;
	logic [Q_IDX_W-1:0]   tail_q;
	logic [Q_CNT_W-1:0]   fill_q;
	logic                 out_valid_q;

	// storage
	logic [TAG_W-1:0]  queue_tag_q  [QUEUE_DEPTH];
	logic [TIME_W-1:0] queue_time_q [QUEUE_DEPTH];
	logic [TAG_W-1:0]  srv_tag_q    [MAX_SERVERS];
	logic [TIME_W-1:0] srv_rem_q    [MAX_SERVERS];

	// latched request
	logic [TAG_W-1:0]  tag_s1;
	logic [TIME_W-1:0] time_s1;

	// output payload
	result_kind_t         kind_q;
	logic [SRV_IDX_W-1:0] index_q;
	logic [TAG_W-1:0]     otag_q;
	logic [TIME_W-1:0]    otime_q;
	logic                 busy_q;
	logic                 last_q;

	// combinational
	logic [SRV_CNT_W-1:0] srv_n;
	logic                 last_visit;
	logic                 out_free;
	logic                 q_nonempty;
	logic                 q_full;
	logic [TIME_W-1:0]    rem_cur;
	logic                 take;
	logic                 active;
	logic [TAG_W-1:0]     visit_tag;
	logic [TIME_W-1:0]    visit_rem;
	logic [TIME_W-1:0]    rem_dec;
	logic                 push;
	logic                 pop;
	logic [Q_IDX_W-1:0]   head_inc;
	logic [Q_IDX_W-1:0]   tail_inc;

	// active server count, clamped to the table size
	always_comb begin
		srv_n = (server_count_q > SRV_CNT_W'(MAX_SERVERS)) ?
			SRV_CNT_W'(MAX_SERVERS) : server_count_q;
		last_visit = ((SRV_CNT_W + 1)'(idx_q) + 1'b1) == (SRV_CNT_W + 1)'(srv_n);
	end

	// queue status and ring pointer wrap
	always_comb begin
		q_nonempty = (fill_q != '0);
		q_full     = (fill_q == Q_CNT_W'(QUEUE_DEPTH));
		head_inc   = (head_q == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_inc   = (tail_q == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	end

	// visit of the current server: take the queue head when idle, then count down
	always_comb begin
		rem_cur   = srv_rem_q[idx_q];
		take      = (rem_cur == '0) && q_nonempty;
		active    = q_nonempty || (rem_cur != '0);
		visit_tag = take ? queue_tag_q[head_q] : srv_tag_q[idx_q];
		visit_rem = take ? queue_time_q[head_q] : rem_cur;
		rem_dec   = (visit_rem == '0) ? '0 : visit_rem - 1'b1;
		push      = cmd.arrive && !q_full;
		pop       = cmd.visit && take;
	end

	// output slot can load when empty or being taken
	assign out_free = !out_valid_q || !out_stall;

	// status to the controller
	always_comb begin
		stat.in_tick    = (func == FUNC_TICK);
		stat.count_zero = (server_count_q == '0);
		stat.last_visit = last_visit;
		stat.out_free   = out_free;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= SRV_CNT_W'(1);
		end else if (cfg_we) begin
			server_count_q <= cfg_data;
		end
	end

	// server index counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load_in) begin
			idx_q <= '0;
		end else if (cmd.visit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_inc;
				fill_q <= fill_q + 1'b1;
			end else if (pop) begin
				head_q <= head_inc;
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// queue storage, undefined until written
	always_ff @(posedge clk) begin
		if (push) begin
			queue_tag_q[tail_q]  <= tag_s1;
			queue_time_q[tail_q] <= time_s1;
		end
	end

	// server table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SERVERS; i++) begin
				srv_tag_q[i] <= '0;
				srv_rem_q[i] <= '0;
			end
		end else if (cmd.visit && active) begin
			srv_tag_q[idx_q] <= visit_tag;
			srv_rem_q[idx_q] <= rem_dec;
		end
	end

	// request latch with service time product
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			tag_s1  <= job_tag;
			time_s1 <= TIME_W'(job_weight) * TIME_W'(job_amount);
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.arrive || cmd.visit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.arrive) begin
			kind_q  <= q_full ? KIND_DROP : KIND_ACCEPT;
			index_q <= '0;
			otag_q  <= tag_s1;
			otime_q <= time_s1;
			busy_q  <= 1'b0;
			last_q  <= 1'b1;
		end else if (cmd.visit) begin
			kind_q  <= KIND_STATUS;
			index_q <= idx_q;
			otag_q  <= active ? visit_tag : '0;
			otime_q <= active ? visit_rem : '0;
			busy_q  <= active;
			last_q  <= last_visit;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign server_index = index_q;
	assign served_tag   = otag_q;
	assign time_left    = otime_q;
	assign server_busy  = busy_q;
	assign last_of_run  = last_q;

	// checks
	`ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= Q_CNT_W'(QUEUE_DEPTH), "queue fill over depth")
	`ASSERT_SAME(a_visit_range, cmd.visit, idx_q < srv_n, "server visit beyond active count")
	`ASSERT_NEXT(a_pop_fill, pop, fill_q == $past(fill_q) - 1'b1, "pop did not drop fill by one")
	`ASSERT_SAME(a_load_free, cmd.arrive || cmd.visit, out_free, "result loaded into busy slot")

endmodule

`default_nettype wire

@@ hw/rtl/fcfs_multi_server_dispatcher.sv @@
// First come, first served job dispatcher for several servers.
// Input channel (in_valid / in_stall): func 0 is a job arrival with tag, weight
// and amount; the service time is weight times amount. func 1 is one time tick.
// Output channel (out_valid / out_stall): one result per arrival (accepted or
// dropped when the 16-entry queue is full), and one status result per active
// server per tick, server 0 first, the last one marked with last_of_run.
// Config channel (cfg_valid / cfg_ready): writes server_count, taken in any
// cycle; write it only while no request is in flight.
// Timing: a request is taken only when the previous one has loaded all of its
// results. The controller then enters the arrive or visit state and registers
// the first result when the output register is free. Sharing the queue and
// server table, server visits run one per cycle while the output register is
// free. A tick with server_count zero gives no result.
// When the receiver stalls, the result holds in the output register and the
// visit sequence waits; a new request is still taken while a result waits.
// Reset clears the queue pointers, idles all servers and sets server_count to 1.
// depends on fcfsd_pkg, fcfsd_ctrl, fcfsd_datapath
`timescale 1ns / 1ps
`default_nettype none

module fcfs_multi_server_dispatcher
	import fcfsd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [SRV_CNT_W-1:0] cfg_data,
	// request channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 func,
	input  wire logic [TAG_W-1:0]     job_tag,
	input  wire logic [FACT_W-1:0]    job_weight,
	input  wire logic [FACT_W-1:0]    job_amount,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                result_kind,
	output logic [SRV_IDX_W-1:0]      server_index,
	output logic [TAG_W-1:0]          served_tag,
	output logic [TIME_W-1:0]         time_left,
	output logic                      server_busy,
	output logic                      last_of_run
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	// config register always accepts
	assign cfg_ready = 1'b1;

	// controller
	fcfsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	fcfsd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.func         (func),
		.job_tag      (job_tag),
		.job_weight   (job_weight),
		.job_amount   (job_amount),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.server_index (server_index),
		.served_tag   (served_tag),
		.time_left    (time_left),
		.server_busy  (server_busy),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire

@@ tb/fcfsd_dispatch_checker.sv @@
// result checker for the fcfs dispatcher: mirrors the queue and server table,
// predicts the results of every request taken and compares the result channel
// depends on fcfsd_pkg
`timescale 1ns / 1ps

module fcfsd_dispatch_checker
	import fcfsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [SRV_CNT_W-1:0] cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 func,
	input  logic [TAG_W-1:0]     job_tag,
	input  logic [FACT_W-1:0]    job_weight,
	input  logic [FACT_W-1:0]    job_amount,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [1:0]           result_kind,
	input  logic [SRV_IDX_W-1:0] server_index,
	input  logic [TAG_W-1:0]     served_tag,
	input  logic [TIME_W-1:0]    time_left,
	input  logic                 server_busy,
	input  logic                 last_of_run,
	output int                   mismatches,
	output int                   reports_owed
);

	typedef struct packed {
		result_kind_t         kind;
		logic [SRV_IDX_W-1:0] server;
		logic [TAG_W-1:0]     tag;
		logic [TIME_W-1:0]    left;
		logic                 busy;
		logic                 last;
	} report_t;

	// results still to come, oldest first
	report_t owed_reports[$];
	report_t seen;

	// mirror of the job ring, the server table and the active server count
	logic [TAG_W-1:0]     ring_tag[QUEUE_DEPTH];
	logic [TIME_W-1:0]    ring_time[QUEUE_DEPTH];
	int                   ring_head = 0;
	int                   ring_fill = 0;
	logic [TAG_W-1:0]     srv_tag[MAX_SERVERS];
	logic [TIME_W-1:0]    srv_left[MAX_SERVERS];
	logic [SRV_CNT_W-1:0] active_servers = SRV_CNT_W'(1);

	int fails = 0;
	int owed = 0;

	assign mismatches   = fails;
	assign reports_owed = owed;

	// work out the results of one request and advance the mirror
	task automatic dispatch_request(input logic kind_bit, input logic [TAG_W-1:0] tag,
		input logic [FACT_W-1:0] weight, input logic [FACT_W-1:0] amount);
		logic [TIME_W-1:0] wide_weight;
		logic [TIME_W-1:0] wide_amount;
		logic [TIME_W-1:0] service;
		report_t rep;
		int visits;
		int i;
		int slot;
		wide_weight = TIME_W'(weight);
		wide_amount = TIME_W'(amount);
		service = wide_weight * wide_amount;
		if (kind_bit == FUNC_ARRIVE) begin
			rep.server = '0;
			rep.tag    = tag;
			rep.left   = service;
			rep.busy   = 1'b0;
			rep.last   = 1'b1;
			if (ring_fill < QUEUE_DEPTH) begin
				slot = (ring_head + ring_fill) % QUEUE_DEPTH;
				ring_tag[slot]  = tag;
				ring_time[slot] = service;
				ring_fill++;
				rep.kind = KIND_ACCEPT;
			end else begin
				rep.kind = KIND_DROP;
			end
			owed_reports.push_back(rep);
		end else begin
			// counts above the table size act as the table size
			visits = (active_servers > MAX_SERVERS) ? MAX_SERVERS : active_servers;
			for (i = 0; i < visits; i++) begin
				rep.kind   = KIND_STATUS;
				rep.server = SRV_IDX_W'(i);
				rep.last   = (i == visits - 1);
				if (ring_fill > 0 || srv_left[i] != 0) begin
					// an idle server pulls the queue head before it reports
					if (srv_left[i] == 0) begin
						srv_tag[i]  = ring_tag[ring_head];
						srv_left[i] = ring_time[ring_head];
						ring_head   = (ring_head + 1) % QUEUE_DEPTH;
						ring_fill--;
					end
					rep.tag  = srv_tag[i];
					rep.left = srv_left[i];
					rep.busy = 1'b1;
					// countdown stops at zero
					if (srv_left[i] != 0)
						srv_left[i] = srv_left[i] - 1'b1;
				end else begin
					rep.tag  = '0;
					rep.left = '0;
					rep.busy = 1'b0;
				end
				owed_reports.push_back(rep);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// results first: none can stem from a request taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_reports.delete();
			ring_head = 0;
			ring_fill = 0;
			active_servers = SRV_CNT_W'(1);
			for (int s = 0; s < MAX_SERVERS; s++) begin
				srv_tag[s]  = '0;
				srv_left[s] = '0;
			end
			owed = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_reports.size() == 0) begin
					fails++;
					$display("%0t: unexpected result, kind %0d server %0d tag %0d", $time,
						result_kind, server_index, served_tag);
				end else begin
					seen = owed_reports.pop_front();
					check_field("result_kind", 32'(seen.kind), 32'(result_kind));
					check_field("server_index", 32'(seen.server), 32'(server_index));
					check_field("served_tag", 32'(seen.tag), 32'(served_tag));
					check_field("time_left", 32'(seen.left), 32'(time_left));
					check_field("server_busy", 32'(seen.busy), 32'(server_busy));
					check_field("last_of_run", 32'(seen.last), 32'(last_of_run));
				end
			end
			if (cfg_valid && cfg_ready)
				active_servers = cfg_data;
			if (in_valid && !in_stall)
				dispatch_request(func, job_tag, job_weight, job_amount);
			owed = owed_reports.size();
		end
	end

endmodule

@@ tb/fcfs_multi_server_dispatcher_tb.sv @@
// top of the fcfs dispatcher testbench: clock, reset, request and config stimulus,
// random stalls on the result side, and the final verdict
// depends on fcfsd_pkg, fcfs_multi_server_dispatcher, fcfsd_dispatch_checker
`timescale 1ns / 1ps

module fcfs_multi_server_dispatcher_tb;
	import fcfsd_pkg::*;

	localparam int SETTLE_CYCLES   = 16;
	localparam int ITEMS_PER_PHASE = 24;
	localparam int PHASES          = 8;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [SRV_CNT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 func;
	logic [TAG_W-1:0]     job_tag;
	logic [FACT_W-1:0]    job_weight;
	logic [FACT_W-1:0]    job_amount;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           result_kind;
	logic [SRV_IDX_W-1:0] server_index;
	logic [TAG_W-1:0]     served_tag;
	logic [TIME_W-1:0]    time_left;
	logic                 server_busy;
	logic                 last_of_run;
	int                   mismatches;
	int                   reports_owed;
	logic                 calm;

	// server counts of the random phases, extremes included
	logic [SRV_CNT_W-1:0] phase_servers[PHASES] = '{4'd3, 4'd10, 4'd1, 4'd15, 4'd0, 4'd2,
		4'd10, 4'd6};

	fcfs_multi_server_dispatcher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.job_tag      (job_tag),
		.job_weight   (job_weight),
		.job_amount   (job_amount),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.server_index (server_index),
		.served_tag   (served_tag),
		.time_left    (time_left),
		.server_busy  (server_busy),
		.last_of_run  (last_of_run)
	);

	fcfsd_dispatch_checker dispatch_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.job_tag      (job_tag),
		.job_weight   (job_weight),
		.job_amount   (job_amount),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.server_index (server_index),
		.served_tag   (served_tag),
		.time_left    (time_left),
		.server_busy  (server_busy),
		.last_of_run  (last_of_run),
		.mismatches   (mismatches),
		.reports_owed (reports_owed)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver stalls about a third of the time unless the run is calm
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 31);
	end

	// hang guard
	initial begin
		#200000;
		$display("fcfs_multi_server_dispatcher_tb: errors");
		$finish;
	end

	// offer one request after a random gap and hold it until taken
	task automatic send_request(input logic kind_bit, input logic [TAG_W-1:0] tag,
		input logic [FACT_W-1:0] weight, input logic [FACT_W-1:0] amount);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		func       <= kind_bit;
		job_tag    <= tag;
		job_weight <= weight;
		job_amount <= amount;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// mostly short jobs so servers free up, now and then a full-range one
	task automatic random_request(input int arrive_pct);
		logic [FACT_W-1:0] weight;
		logic [FACT_W-1:0] amount;
		if ($urandom_range(99) < 3) begin
			weight = FACT_W'($urandom);
			amount = FACT_W'($urandom);
		end else begin
			weight = FACT_W'($urandom_range(3));
			amount = FACT_W'($urandom_range(5));
		end
		send_request(($urandom_range(99) < arrive_pct) ? FUNC_ARRIVE : FUNC_TICK,
			TAG_W'($urandom), weight, amount);
	endtask

	// stop offering and wait for every owed result, plus a zero-count tick's tail
	task automatic run_dry;
		@(negedge clk);
		in_valid <= 1'b0;
		while (reports_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_servers(input logic [SRV_CNT_W-1:0] count);
		run_dry();
		cfg_valid <= 1'b1;
		cfg_data  <= count;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int k;
		int phase;
		int arrive_pct;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		func       = FUNC_ARRIVE;
		job_tag    = '0;
		job_weight = '0;
		job_amount = '0;
		calm       = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// one server after reset: idle, zero-time job, then idle again
		send_request(FUNC_TICK, 16'h0000, 8'h00, 8'h00);
		send_request(FUNC_ARRIVE, 16'h0000, 8'd0, 8'd255);
		send_request(FUNC_TICK, 16'h0000, 8'h00, 8'h00);
		send_request(FUNC_TICK, 16'h0000, 8'h00, 8'h00);

		// fill the ring, then overflow it with the largest job
		for (k = 0; k < QUEUE_DEPTH; k++)
			send_request(FUNC_ARRIVE, TAG_W'(k * 16'h1111), 8'd1, FACT_W'(1 + k % 3));
		send_request(FUNC_ARRIVE, 16'hffff, 8'd255, 8'd255);
		send_request(FUNC_TICK, 16'hffff, 8'hff, 8'hff);

		// oversized count acts as all servers
		set_servers(4'd15);
		send_request(FUNC_TICK, 16'h0000, 8'h00, 8'h00);
		send_request(FUNC_TICK, 16'h0000, 8'h00, 8'h00);

		// zero count: tick gives nothing
		set_servers(4'd0);
		send_request(FUNC_TICK, 16'h0000, 8'h00, 8'h00);

		// random phases, one of them without any idling
		for (phase = 0; phase < PHASES; phase++) begin
			set_servers((phase == PHASES - 1) ? SRV_CNT_W'($urandom_range(15)) :
				phase_servers[phase]);
			calm = (phase == 1);
			arrive_pct = $urandom_range(25, 75);
			for (k = 0; k < ITEMS_PER_PHASE; k++)
				random_request(arrive_pct);
		end

		calm = 1'b0;
		run_dry();
		if (mismatches == 0)
			$display("fcfs_multi_server_dispatcher_tb: clean");
		else
			$display("fcfs_multi_server_dispatcher_tb: errors");
		$finish;
	end

endmodule
